// ===== sv/swzbf_pkg.sv =====
// ----------------------------------------------------------------------------
// swzbf_pkg
// Shared widths, queue sizing and the command type of the zero-block filter.
// ----------------------------------------------------------------------------
package swzbf_pkg;

	localparam int ADDR_W    = 18;
	localparam int DATA_W    = 8;
	localparam int BUF_DEPTH = 64;
	localparam int IDX_W     = $clog2(BUF_DEPTH);
	localparam int CNT_W     = IDX_W + 1;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	// One command from the front to the back. A segment command stores one
	// byte in the segment buffer and, with flush set, drains the segment.
	typedef struct packed {
		logic              seg;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic              fresh;
		logic [IDX_W-1:0]  idx;
		logic              flush;
	} swzbf_cmd_t;

endpackage

// ===== sv/swzbf_in_if.sv =====
// ----------------------------------------------------------------------------
// swzbf_in_if
// Write-data channel: one payload byte with its store address per transaction.
// ----------------------------------------------------------------------------
interface swzbf_in_if import swzbf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] byte_address;
	logic [DATA_W-1:0] data_byte;
	logic              last_of_write;

	modport source(output valid, byte_address, data_byte, last_of_write, input ready);
	modport sink(input valid, byte_address, data_byte, last_of_write, output ready);
endinterface

// ===== sv/swzbf_out_if.sv =====
// ----------------------------------------------------------------------------
// swzbf_out_if
// Store channel: one byte write to the backing store per transaction.
// ----------------------------------------------------------------------------
interface swzbf_out_if import swzbf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] store_address;
	logic [DATA_W-1:0] store_byte;
	logic              block_allocated_now;
	logic              last_of_burst;

	modport source(output valid, store_address, store_byte, block_allocated_now,
		last_of_burst, input ready);
	modport sink(input valid, store_address, store_byte, block_allocated_now,
		last_of_burst, output ready);
endinterface

// ===== sv/swzbf_ram.sv =====
// ----------------------------------------------------------------------------
// swzbf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module swzbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/swzbf_fifo.sv =====
// ----------------------------------------------------------------------------
// swzbf_fifo
// Short command queue between the classifying front and the store back end.
// ----------------------------------------------------------------------------
module swzbf_fifo import swzbf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  swzbf_cmd_t push_cmd,
	output logic       full,
	input  logic       pop,
	output logic       valid,
	output swzbf_cmd_t head_cmd
);

	swzbf_cmd_t        slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign valid    = (cnt_q != '0);
	assign head_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== sv/swzbf_front.sv =====
// ----------------------------------------------------------------------------
// swzbf_front
// Accepts write bytes, looks up the allocation bitmap and tracks open segments.
// ----------------------------------------------------------------------------
module swzbf_front import swzbf_pkg::*; #(
	parameter int BLOCK_BYTES = 64,
	parameter int NUM_BLOCKS  = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	swzbf_in_if.sink   write_ch,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	output logic       q_push,
	output swzbf_cmd_t q_cmd,
	input  logic       q_full
);

	localparam int BIW = $clog2(NUM_BLOCKS);

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_LOOK = 2'b10
	} front_state_t;

	front_state_t      state_q;
	logic              sparing_q;
	logic              clearing_q;
	logic [BIW-1:0]    clr_idx_q;

	logic [CNT_W-1:0]  seg_cnt_q;
	logic [ADDR_W-1:0] seg_start_q;
	logic [IDX_W-1:0]  seg_off_q;
	logic              seg_zero_q;
	logic [BIW-1:0]    seg_blk_q;

	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] data_q;
	logic              last_q;
	logic [BIW-1:0]    blk_q;

	logic              accept, seg_open, look, bit_set, direct, seg_step;
	logic [BIW-1:0]    blk_in;
	logic [ADDR_W-1:0] s_start, s_cur;
	logic [CNT_W-1:0]  s_cnt, s_cnt_n;
	logic [IDX_W-1:0]  s_off;
	logic              s_zero, s_zero_n, s_last, s_close, s_flush;
	logic [DATA_W-1:0] s_data;
	logic [BIW-1:0]    s_blk;
	logic              bm_we;
	logic [BIW-1:0]    bm_waddr;
	logic              bm_rdata;

	assign seg_open       = (seg_cnt_q != '0);
	assign write_ch.ready = (state_q == F_IDLE) && !clearing_q && !q_full;
	assign accept         = write_ch.valid && write_ch.ready;
	assign look           = (state_q == F_LOOK);
	assign blk_in         = BIW'((32'(write_ch.byte_address) / BLOCK_BYTES) % NUM_BLOCKS);
	assign bit_set        = bm_rdata;
	assign direct         = look && (!sparing_q || bit_set);
	assign seg_step       = (accept && seg_open) || (look && sparing_q && !bit_set);

	// Segment byte: either the next byte of an open segment or the first
	// byte of a segment opened after a miss in the bitmap.
	always_comb begin
		s_start  = look ? addr_q : seg_start_q;
		s_cnt    = look ? '0 : seg_cnt_q;
		s_off    = look ? IDX_W'(32'(addr_q) % BLOCK_BYTES) : seg_off_q;
		s_zero   = look ? 1'b1 : seg_zero_q;
		s_data   = look ? data_q : write_ch.data_byte;
		s_last   = look ? last_q : write_ch.last_of_write;
		s_blk    = look ? blk_q : seg_blk_q;
		s_cur    = s_start + ADDR_W'(s_cnt);
		s_cnt_n  = s_cnt + CNT_W'(1);
		s_zero_n = s_zero && (s_data == '0);
		s_close  = s_last || (s_off == IDX_W'(BLOCK_BYTES - 1)) || (&s_cur)
			|| (s_cnt_n == CNT_W'(BLOCK_BYTES));
		s_flush  = s_close && !s_zero_n;
	end

	always_comb begin
		q_push = direct || seg_step;
		if (direct) begin
			q_cmd = '{seg: 1'b0, addr: addr_q, data: data_q, fresh: !bit_set,
				idx: '0, flush: 1'b0};
		end else begin
			q_cmd = '{seg: 1'b1, addr: s_start, data: s_data, fresh: 1'b1,
				idx: s_cnt[IDX_W-1:0], flush: s_flush};
		end
	end

	always_comb begin
		bm_we    = clearing_q || direct || (seg_step && s_flush);
		bm_waddr = clearing_q ? clr_idx_q : (direct ? blk_q : s_blk);
	end

	swzbf_ram #(
		.WIDTH(1),
		.DEPTH(NUM_BLOCKS)
	) u_bitmap (
		.clk  (clk),
		.we   (bm_we),
		.waddr(bm_waddr),
		.wdata(!clearing_q),
		.re   (accept && !seg_open),
		.raddr(blk_in),
		.rdata(bm_rdata)
	);

	always_ff @(posedge clk) begin
		if (accept && !seg_open) begin
			addr_q <= write_ch.byte_address;
			data_q <= write_ch.data_byte;
			last_q <= write_ch.last_of_write;
			blk_q  <= blk_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			sparing_q   <= 1'b1;
			clearing_q  <= 1'b1;
			clr_idx_q   <= '0;
			seg_cnt_q   <= '0;
			seg_start_q <= '0;
			seg_off_q   <= '0;
			seg_zero_q  <= 1'b1;
			seg_blk_q   <= '0;
		end else begin
			if (cfg_we) begin
				sparing_q <= cfg_wdata;
			end
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + BIW'(1);
				if (clr_idx_q == BIW'(NUM_BLOCKS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			case (state_q)
				F_IDLE: begin
					if (accept && !seg_open) begin
						state_q <= F_LOOK;
					end
				end
				F_LOOK: begin
					state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
			if (seg_step) begin
				if (s_close) begin
					seg_cnt_q  <= '0;
					seg_zero_q <= 1'b1;
				end else begin
					seg_cnt_q   <= s_cnt_n;
					seg_start_q <= s_start;
					seg_off_q   <= s_off + IDX_W'(1);
					seg_zero_q  <= s_zero_n;
					seg_blk_q   <= s_blk;
				end
			end
		end
	end

endmodule

// ===== sv/swzbf_back.sv =====
// ----------------------------------------------------------------------------
// swzbf_back
// Executes queued commands: direct store writes and segment buffer flushes.
// ----------------------------------------------------------------------------
module swzbf_back import swzbf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  swzbf_cmd_t  q_cmd,
	output logic        q_pop,
	swzbf_out_if.source store_ch
);

	typedef enum logic [1:0] {
		B_IDLE  = 2'b01,
		B_FLUSH = 2'b10
	} back_state_t;

	back_state_t       state_q;
	logic [ADDR_W-1:0] start_q;
	logic [CNT_W-1:0]  n_q;
	logic              fresh_q;
	logic [CNT_W-1:0]  rd_k_q;
	logic              v1_q;
	logic [IDX_W-1:0]  k1_q;

	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [DATA_W-1:0] out_byte_q;
	logic              out_fresh_q;
	logic              out_last_q;

	logic              slot_free, flushing, advance, issue, load_direct;
	logic [DATA_W-1:0] buf_rdata;

	assign slot_free   = !out_valid_q || store_ch.ready;
	assign flushing    = (state_q == B_FLUSH);
	assign q_pop       = (state_q == B_IDLE) && q_valid && (q_cmd.seg || slot_free);
	assign load_direct = q_pop && !q_cmd.seg;
	assign advance     = flushing && v1_q && slot_free;
	assign issue       = flushing && (rd_k_q < n_q) && (!v1_q || advance);

	swzbf_ram #(
		.WIDTH(DATA_W),
		.DEPTH(BUF_DEPTH)
	) u_segbuf (
		.clk  (clk),
		.we   (q_pop && q_cmd.seg),
		.waddr(q_cmd.idx),
		.wdata(q_cmd.data),
		.re   (issue),
		.raddr(rd_k_q[IDX_W-1:0]),
		.rdata(buf_rdata)
	);

	assign store_ch.valid               = out_valid_q;
	assign store_ch.store_address       = out_addr_q;
	assign store_ch.store_byte          = out_byte_q;
	assign store_ch.block_allocated_now = out_fresh_q;
	assign store_ch.last_of_burst       = out_last_q;

	always_ff @(posedge clk) begin
		if (load_direct) begin
			out_addr_q  <= q_cmd.addr;
			out_byte_q  <= q_cmd.data;
			out_fresh_q <= q_cmd.fresh;
			out_last_q  <= 1'b1;
		end else if (advance) begin
			out_addr_q  <= start_q + ADDR_W'(k1_q);
			out_byte_q  <= buf_rdata;
			out_fresh_q <= fresh_q && (k1_q == '0);
			out_last_q  <= ((CNT_W'(k1_q) + CNT_W'(1)) == n_q);
		end
		if (q_pop && q_cmd.seg && q_cmd.flush) begin
			start_q <= q_cmd.addr;
			n_q     <= CNT_W'(q_cmd.idx) + CNT_W'(1);
			fresh_q <= q_cmd.fresh;
		end
		if (issue) begin
			k1_q <= rd_k_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			rd_k_q      <= '0;
			v1_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_direct || advance) begin
				out_valid_q <= 1'b1;
			end else if (store_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_pop && q_cmd.seg && q_cmd.flush) begin
						state_q <= B_FLUSH;
						rd_k_q  <= '0;
						v1_q    <= 1'b0;
					end
				end
				B_FLUSH: begin
					if (issue) begin
						rd_k_q <= rd_k_q + CNT_W'(1);
						v1_q   <= 1'b1;
					end else if (advance) begin
						v1_q <= 1'b0;
					end
					if ((rd_k_q == n_q) && (!v1_q || advance)) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/sparse_write_zero_block_filter.sv =====
// ----------------------------------------------------------------------------
// sparse_write_zero_block_filter
// Drops all-zero write segments that fall in unallocated storage blocks.
// ----------------------------------------------------------------------------
// Throughput: a byte that continues an open segment needs no bitmap lookup; a
// byte with no segment open holds off the next for the registered bitmap read.
// Store bytes leave at one per cycle while the store side is ready; a flush
// holds the back end. A direct write passes the lookup register, the queue
// and the store output register. Reset: arst_n clears control state, then a
// clearing pass zeroes the bitmap, during which no write transaction is accepted.
module sparse_write_zero_block_filter import swzbf_pkg::*; #(
	parameter int BLOCK_BYTES = 64,
	parameter int NUM_BLOCKS  = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	swzbf_in_if.sink    write_ch,
	swzbf_out_if.source store_ch,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	// The front classifies each write byte against the allocation bitmap.
	// Bytes of allocated blocks (or all bytes with sparing off) become direct
	// commands; bytes of unallocated blocks become segment commands that the
	// back end stores in its segment buffer and drains when the segment
	// closes with at least one nonzero byte.
	swzbf_cmd_t push_cmd;
	swzbf_cmd_t head_cmd;
	logic       push, full, pop, head_valid;

	swzbf_front #(
		.BLOCK_BYTES(BLOCK_BYTES),
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.write_ch (write_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_push   (push),
		.q_cmd    (push_cmd),
		.q_full   (full)
	);

	// The queue lets the front keep taking bytes of the next segment while
	// the back end is still draining an earlier one.
	swzbf_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (full),
		.pop     (pop),
		.valid   (head_valid),
		.head_cmd(head_cmd)
	);

	// The back end owns the segment buffer and the store output register.
	swzbf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (head_valid),
		.q_cmd   (head_cmd),
		.q_pop   (pop),
		.store_ch(store_ch)
	);

endmodule

// ===== sim/sparse_write_zero_block_filter_test.sv =====
// ----------------------------------------------------------------------------
// sparse_write_zero_block_filter_test
// Self-checking bench for the zero-block filter. A behavioral copy of the
// filter predicts every store write from each accepted write byte; a sink
// process compares the store channel against those predictions in order.
// ----------------------------------------------------------------------------
module sparse_write_zero_block_filter_test;
	import swzbf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLOCK_BYTES  = 64;
	localparam int NUM_BLOCKS   = 4096;
	localparam int ADDR_MAX     = (1 << ADDR_W) - 1;
	localparam int POOL_SIZE    = 16;
	localparam int MAX_REPORTS  = 10;
	// Cycles to wait after the last expected store write before touching the
	// register.
	localparam int DRAIN_PAD    = 80;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int HOLD_CYCLES  = 400;
	localparam int TIMEOUT_NS   = 200000;

	// How a random write request is shaped.
	typedef enum int {
		SHAPE_LONE,        // one byte with random address, data and last flag
		SHAPE_BROKEN,      // bytes that jump around and never end the write
		SHAPE_WELL_FORMED  // consecutive bytes closed by last_of_write
	} write_shape_t;

	// What the payload of a random write looks like.
	typedef enum int {
		FILL_ZERO,
		FILL_RANDOM,
		FILL_SPARSE
	} payload_fill_t;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] value;
		logic              fresh;
		logic              last;
	} store_write_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	swzbf_in_if  write_if();
	swzbf_out_if store_if();

	sparse_write_zero_block_filter #(
		.BLOCK_BYTES(BLOCK_BYTES),
		.NUM_BLOCKS (NUM_BLOCKS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.write_ch (write_if),
		.store_ch (store_if),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1ns clk = ~clk;

	// Shadow copy of the filter state, updated as each write byte is accepted.
	bit                alloc_map [NUM_BLOCKS];
	logic [DATA_W-1:0] seg_bytes [BUF_DEPTH];
	logic [ADDR_W-1:0] seg_base;
	int unsigned       seg_fill;
	bit                seg_zero;
	bit                spare_mode;

	// Store writes the block still owes us, oldest first.
	store_write_t pending_store_writes[$];

	int          mismatches;
	int          random_bytes;
	int          hold_cycles;
	bit          quiet_links;
	int unsigned block_pool [POOL_SIZE];

	// Work out which store writes one accepted write byte causes. A byte with
	// no segment open either goes straight through or opens a segment in an
	// unallocated block; a byte with a segment open always extends it, and the
	// address that came with it plays no part.
	function automatic void filter_write_byte(input logic [ADDR_W-1:0] a,
		input logic [DATA_W-1:0] d, input logic l);
		int unsigned       blk;
		int unsigned       n;
		logic [ADDR_W-1:0] cur;
		bit                fresh;
		bit                close;
		store_write_t      w;

		if (seg_fill == 0) begin
			blk = (a / BLOCK_BYTES) % NUM_BLOCKS;
			if (!spare_mode || alloc_map[blk]) begin
				fresh = !alloc_map[blk];
				alloc_map[blk] = 1'b1;
				w.addr  = a;
				w.value = d;
				w.fresh = fresh;
				w.last  = 1'b1;
				pending_store_writes.push_back(w);
				return;
			end
			seg_base = a;
			seg_zero = 1'b1;
		end

		cur = seg_base + ADDR_W'(seg_fill);
		seg_bytes[seg_fill % BUF_DEPTH] = d;
		seg_fill++;
		if (d != '0)
			seg_zero = 1'b0;

		// A segment ends with the write, at a block boundary, at the top of
		// the store, or when it has filled a whole block.
		close = l || (cur % BLOCK_BYTES) == BLOCK_BYTES - 1 || cur == ADDR_W'(ADDR_MAX)
			|| seg_fill >= BLOCK_BYTES || seg_fill >= BUF_DEPTH;
		if (!close)
			return;

		n = seg_fill;
		seg_fill = 0;
		// An all-zero segment leaves the store and the bitmap untouched.
		if (seg_zero)
			return;
		seg_zero = 1'b1;

		blk = (seg_base / BLOCK_BYTES) % NUM_BLOCKS;
		fresh = !alloc_map[blk];
		alloc_map[blk] = 1'b1;
		for (int unsigned k = 0; k < n; k++) begin
			w.addr  = seg_base + ADDR_W'(k);
			w.value = seg_bytes[k % BUF_DEPTH];
			w.fresh = fresh && k == 0;
			w.last  = (k + 1 == n);
			pending_store_writes.push_back(w);
		end
	endfunction

	// Compare one store transaction with the oldest prediction.
	function automatic void check_store_write(input logic [ADDR_W-1:0] a,
		input logic [DATA_W-1:0] v, input logic f, input logic l);
		store_write_t want;

		if (pending_store_writes.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("unexpected store write: addr %h byte %h fresh %b last %b",
					a, v, f, l);
			return;
		end
		want = pending_store_writes.pop_front();
		if (a !== want.addr || v !== want.value || f !== want.fresh || l !== want.last) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("store write mismatch: expected addr %h byte %h fresh %b last %b",
					want.addr, want.value, want.fresh, want.last);
				$display("                      got      addr %h byte %h fresh %b last %b",
					a, v, f, l);
			end
		end
	endfunction

	// Store-side sink. Each store transaction is checked as it is accepted.
	// After every transaction the sink draws a short stall unless the links are quiet;
	// on top of that the stimulus can ask for a long hold-off, which is counted down here.
	initial begin : store_sink
		int stall;

		store_if.ready = 1'b0;
		stall = 0;
		forever begin
			@(posedge clk);
			if (store_if.valid && store_if.ready) begin
				check_store_write(store_if.store_address, store_if.store_byte,
					store_if.block_allocated_now, store_if.last_of_burst);
				stall = quiet_links ? 0 : $urandom_range(0, 5);
			end
			if (hold_cycles > 0) begin
				store_if.ready <= 1'b0;
				hold_cycles--;
			end else if (stall > 0) begin
				store_if.ready <= 1'b0;
				stall--;
			end else begin
				store_if.ready <= 1'b1;
			end
		end
	end

	// Offer one write byte after a random gap and wait for the transaction.
	// The task returns at the edge that accepted it with valid still high, so
	// a following byte with no gap keeps valid up without a glitch.
	task automatic send_write_byte(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d,
		input logic l);
		int gap;

		gap = quiet_links ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			write_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		write_if.valid         <= 1'b1;
		write_if.byte_address  <= a;
		write_if.data_byte     <= d;
		write_if.last_of_write <= l;
		do
			@(posedge clk);
		while (!write_if.ready);
		filter_write_byte(a, d, l);
	endtask

	// Stop offering, wait for every owed store write, then let any silent work
	// (an open or dropped segment) run out before the next phase.
	task automatic settle();
		int waited;

		write_if.valid <= 1'b0;
		waited = 0;
		while (pending_store_writes.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	// The register is written only after settle(); a segment may still be open.
	task automatic set_sparing(input logic v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		spare_mode  = v;
	endtask

	// Draw a fresh set of blocks for random writes, keeping the first and the
	// last block of the store in the set so both ends of the address are hit.
	task automatic refresh_pool();
		block_pool[0] = 0;
		block_pool[1] = NUM_BLOCKS - 1;
		for (int i = 2; i < POOL_SIZE; i++)
			block_pool[i] = $urandom_range(0, NUM_BLOCKS - 1);
	endtask

	function automatic logic [ADDR_W-1:0] pick_store_address();
		int unsigned offset;
		int unsigned roll;

		roll = $urandom_range(0, 5);
		if (roll < 2)
			offset = 0;
		else if (roll == 2)
			offset = BLOCK_BYTES - 1;
		else
			offset = $urandom_range(0, BLOCK_BYTES - 1);
		return ADDR_W'(block_pool[$urandom_range(0, POOL_SIZE - 1)] * BLOCK_BYTES + offset);
	endfunction

	// One random write request. Most are well formed so that segments open,
	// fill and close; the rest are lone bytes and writes that never finish.
	task automatic send_random_write();
		int                roll;
		int                len;
		write_shape_t      shape;
		payload_fill_t     fill;
		logic [ADDR_W-1:0] a;
		logic [DATA_W-1:0] d;
		logic              l;

		roll = $urandom_range(0, 99);
		if (roll < 12)
			shape = SHAPE_LONE;
		else if (roll < 25)
			shape = SHAPE_BROKEN;
		else
			shape = SHAPE_WELL_FORMED;

		if (shape == SHAPE_LONE) begin
			send_write_byte(ADDR_W'($urandom_range(0, ADDR_MAX)),
				DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			random_bytes++;
			return;
		end

		a    = pick_store_address();
		len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 70) : $urandom_range(1, 12);
		fill = payload_fill_t'($urandom_range(0, 2));
		for (int k = 0; k < len; k++) begin
			case (fill)
				FILL_ZERO:   d = '0;
				FILL_RANDOM: d = DATA_W'($urandom_range(0, 255));
				default:     d = DATA_W'(($urandom_range(0, 15) == 0) ?
					$urandom_range(1, 255) : 0);
			endcase
			if (shape == SHAPE_BROKEN) begin
				// Jump somewhere else now and then; an open segment ignores it.
				if ($urandom_range(0, 3) == 0)
					a = ADDR_W'($urandom_range(0, ADDR_MAX));
				l = 1'b0;
			end else begin
				l = (k == len - 1);
			end
			send_write_byte(a, d, l);
			random_bytes++;
			a = a + 1'b1;
		end
	endtask

	// Random writes until count bytes have gone in. With hold_after set, the
	// store side is held off once that many bytes have passed, while writes
	// keep coming so that the block backs up and stalls its input.
	task automatic run_random_writes(input int count, input int hold_after);
		int start;
		bit held;

		start = random_bytes;
		held  = 1'b0;
		while (random_bytes - start < count) begin
			if (hold_after >= 0 && !held && random_bytes - start >= hold_after) begin
				hold_cycles = HOLD_CYCLES;
				held = 1'b1;
			end
			send_random_write();
		end
	endtask

	// ---- Directed tests ------------------------------------------------

	// All-zero bytes in an unallocated block are swallowed without a trace.
	task automatic test_zero_segment_dropped();
		for (int k = 0; k < 4; k++)
			send_write_byte(ADDR_W'(k), 8'h00, k == 3);
	endtask

	// A byte at the very top of the store closes its segment on its own.
	task automatic test_top_address_close();
		send_write_byte(ADDR_W'(ADDR_MAX), 8'hFF, 1'b1);
	endtask

	// A segment with one nonzero byte is written out whole, zero byte too.
	task automatic test_nonzero_segment_emitted();
		send_write_byte(18'd100, 8'h00, 1'b0);
		send_write_byte(18'd101, 8'h80, 1'b1);
	endtask

	// Once a block is allocated, even a zero byte goes straight through.
	task automatic test_allocated_pass_through();
		send_write_byte(18'd102, 8'h00, 1'b1);
	endtask

	// While a segment is open the byte address is not looked at: the second
	// byte lands right after the first even though it claims the top address.
	task automatic test_open_segment_ignores_address();
		send_write_byte(18'd5000, 8'h01, 1'b0);
		send_write_byte(ADDR_W'(ADDR_MAX), 8'h00, 1'b1);
	endtask

	// Sparing is switched off with a segment open. The open segment still
	// finishes under the sparing rules and is dropped; the next byte then
	// goes straight through and allocates the same block.
	task automatic test_sparing_change_mid_segment();
		send_write_byte(18'd9000, 8'h00, 1'b0);
		set_sparing(1'b0);
		send_write_byte(18'd9001, 8'h00, 1'b1);
		send_write_byte(18'd9002, 8'h00, 1'b0);
	endtask

	// With sparing off, the first write to a block flags the allocation and
	// the second does not.
	task automatic test_direct_writes();
		send_write_byte(18'd0, 8'h00, 1'b0);
		send_write_byte(18'd1, 8'h00, 1'b1);
	endtask

	// A write that runs over a block boundary becomes two segments, each
	// allocating its own block.
	task automatic test_block_boundary_split();
		set_sparing(1'b1);
		send_write_byte(18'd190, 8'h11, 1'b0);
		send_write_byte(18'd191, 8'h22, 1'b0);
		send_write_byte(18'd192, 8'h33, 1'b0);
		send_write_byte(18'd193, 8'h44, 1'b1);
	endtask

	// ---- Random tests --------------------------------------------------

	task automatic test_random_sparing_on();
		set_sparing(1'b1);
		refresh_pool();
		run_random_writes(200, 60);
	endtask

	task automatic test_random_direct();
		set_sparing(1'b0);
		refresh_pool();
		run_random_writes(80, -1);
	endtask

	// Back-to-back transactions on both sides first, then idling again.
	task automatic test_random_no_idling();
		set_sparing(1'b1);
		refresh_pool();
		quiet_links = 1'b1;
		run_random_writes(70, -1);
		quiet_links = 1'b0;
		run_random_writes(60, -1);
	endtask

	initial begin
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_wdata              = 1'b0;
		write_if.valid         = 1'b0;
		write_if.byte_address  = '0;
		write_if.data_byte     = '0;
		write_if.last_of_write = 1'b0;

		// Shadow state as it stands right after reset.
		foreach (alloc_map[i])
			alloc_map[i] = 1'b0;
		seg_base     = '0;
		seg_fill     = 0;
		seg_zero     = 1'b1;
		spare_mode   = 1'b1;
		mismatches   = 0;
		random_bytes = 0;
		hold_cycles  = 0;
		quiet_links  = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// The block clears its bitmap after reset; the first transactions
		// simply wait on ready until that pass is over.
		test_zero_segment_dropped();
		test_top_address_close();
		test_nonzero_segment_emitted();
		test_allocated_pass_through();
		test_open_segment_ignores_address();
		test_sparing_change_mid_segment();
		test_direct_writes();
		test_block_boundary_split();
		test_random_sparing_on();
		test_random_direct();
		test_random_no_idling();

		settle();
		if (mismatches == 0 && pending_store_writes.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS * 1ns);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
